// ----- design/tmadc_pkg.sv -----
// Shared constants and types of the two-channel trimmed-mean ADC filter.
package tmadc_pkg;

  localparam int unsigned SAMPLES_PER_CHANNEL = 8;
  localparam int unsigned SAMPLE_BITS = 12;

  localparam int unsigned IN_W = 12;
  localparam int unsigned OUT_W = 12;
  localparam int unsigned SMP_W = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  localparam int unsigned SCAN_LEN = 2 * SAMPLES_PER_CHANNEL;
  localparam int unsigned POS_W = $clog2(SCAN_LEN);
  localparam int unsigned SUM_W = SMP_W + $clog2(SAMPLES_PER_CHANNEL);
  localparam int unsigned DIV = SAMPLES_PER_CHANNEL - 2;
  localparam int unsigned DIV_W = (DIV < 2) ? 1 : $clog2(DIV + 1);
  localparam int unsigned RECIP_SH = SUM_W + DIV_W;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + DIV - 1) / DIV;
  localparam int unsigned RECIP_W = RECIP_SH + 1;
  localparam int unsigned PROD_W = SUM_W + RECIP_W;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] temp_rest;
    logic [SUM_W-1:0] sense_rest;
  } scan_word_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_ctl_t;

endpackage

// ----- design/two_channel_trimmed_mean_adc_filter.sv -----
// Top level of the two-channel trimmed-mean ADC filter.
//
// One sample word is taken per clock while busy is low; a scan is 2 * SAMPLES_PER_CHANNEL
// words, temperature first in each pair. Both trimmed means of a scan appear on the result
// ports and are held there; done_o marks them for one cycle. The word of a finished scan is
// written into the queue; from there the back part divides both channels by
// SAMPLES_PER_CHANNEL - 2 with a reciprocal multiply and registers the means with done_o.
// The back part takes a waiting word from the two-word queue in every cycle, so the queue
// never fills and busy, which is high only while it is full, stays low. The receiver cannot
// stall and must take each result in its cycle.
module two_channel_trimmed_mean_adc_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [tmadc_pkg::IN_W-1:0]  sample_i,
  output logic                        done_o,
  output logic [tmadc_pkg::OUT_W-1:0] temp_filtered_o,
  output logic [tmadc_pkg::OUT_W-1:0] sense_filtered_o
);

  tmadc_pkg::queue_ctl_t ctl;
  tmadc_pkg::scan_word_t front_word, back_word;
  logic                  accept;

  assign accept = start && !busy;
  assign busy   = ctl.full;

  tmadc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_i[tmadc_pkg::SMP_W-1:0]),
    .push_o   (ctl.push),
    .word_o   (front_word)
  );

  tmadc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ctl.push),
    .word_i  (front_word),
    .pop_i   (ctl.pop),
    .word_o  (back_word),
    .full_o  (ctl.full),
    .empty_o (ctl.empty)
  );

  tmadc_divider u_divider (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (ctl.empty),
    .word_i           (back_word),
    .pop_o            (ctl.pop),
    .done_o           (done_o),
    .temp_filtered_o  (temp_filtered_o),
    .sense_filtered_o (sense_filtered_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.push && ctl.full))
    else $error("Scan word pushed into a full queue.");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.pop && ctl.empty))
    else $error("Divider started on an empty queue.");

  a_done_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Results issued on consecutive cycles.");

  a_pop_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ctl.empty) |-> ctl.pop)
    else $error("Divider idle while a scan word waits.");

endmodule

// ----- design/tmadc_front.sv -----
// Front part: folds samples into per-channel sum, minimum and maximum.
module tmadc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [tmadc_pkg::SMP_W-1:0]     sample_i,
  output logic                            push_o,
  output tmadc_pkg::scan_word_t           word_o
);

  logic [tmadc_pkg::POS_W-1:0] pos_q, pos_d;
  logic [tmadc_pkg::SUM_W-1:0] t_sum_q, t_sum_d, s_sum_q, s_sum_d;
  logic [tmadc_pkg::SMP_W-1:0] t_lo_q, t_lo_d, t_hi_q, t_hi_d;
  logic [tmadc_pkg::SMP_W-1:0] s_lo_q, s_lo_d, s_hi_q, s_hi_d;
  logic                        odd, first, last;
  logic [tmadc_pkg::SUM_W-1:0] smp_ext;

  assign odd     = pos_q[0];
  assign first   = (pos_q[tmadc_pkg::POS_W-1:1] == '0);
  assign last    = (pos_q == tmadc_pkg::POS_W'(tmadc_pkg::SCAN_LEN - 1));
  assign smp_ext = tmadc_pkg::SUM_W'(sample_i);

  always_comb begin
    pos_d   = pos_q;
    t_sum_d = t_sum_q;
    t_lo_d  = t_lo_q;
    t_hi_d  = t_hi_q;
    s_sum_d = s_sum_q;
    s_lo_d  = s_lo_q;
    s_hi_d  = s_hi_q;
    if (accept_i) begin
      pos_d = last ? '0 : pos_q + tmadc_pkg::POS_W'(1);
      if (!odd) begin
        if (first) begin
          t_sum_d = smp_ext;
          t_lo_d  = sample_i;
          t_hi_d  = sample_i;
        end else begin
          t_sum_d = t_sum_q + smp_ext;
          if (sample_i < t_lo_q) t_lo_d = sample_i;
          if (sample_i > t_hi_q) t_hi_d = sample_i;
        end
      end else begin
        if (first) begin
          s_sum_d = smp_ext;
          s_lo_d  = sample_i;
          s_hi_d  = sample_i;
        end else begin
          s_sum_d = s_sum_q + smp_ext;
          if (sample_i < s_lo_q) s_lo_d = sample_i;
          if (sample_i > s_hi_q) s_hi_d = sample_i;
        end
      end
    end
  end

  assign push_o = accept_i && last;
  assign word_o.temp_rest = t_sum_q - tmadc_pkg::SUM_W'(t_lo_q) - tmadc_pkg::SUM_W'(t_hi_q);
  assign word_o.sense_rest = s_sum_d - tmadc_pkg::SUM_W'(s_lo_d) - tmadc_pkg::SUM_W'(s_hi_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      t_sum_q <= '0;
      t_lo_q  <= '0;
      t_hi_q  <= '0;
      s_sum_q <= '0;
      s_lo_q  <= '0;
      s_hi_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      t_sum_q <= t_sum_d;
      t_lo_q  <= t_lo_d;
      t_hi_q  <= t_hi_d;
      s_sum_q <= s_sum_d;
      s_lo_q  <= s_lo_d;
      s_hi_q  <= s_hi_d;
    end
  end

endmodule

// ----- design/tmadc_queue.sv -----
// Two-word queue between the accumulating front and the dividing back.
module tmadc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tmadc_pkg::scan_word_t word_i,
  input  logic                  pop_i,
  output tmadc_pkg::scan_word_t word_o,
  output logic                  full_o,
  output logic                  empty_o
);

  tmadc_pkg::scan_word_t         mem_q [tmadc_pkg::Q_DEPTH];
  logic [tmadc_pkg::QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [tmadc_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == tmadc_pkg::QCNT_W'(tmadc_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign word_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == tmadc_pkg::QPTR_W'(tmadc_pkg::Q_DEPTH - 1)) ? '0
           : wr_q + tmadc_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == tmadc_pkg::QPTR_W'(tmadc_pkg::Q_DEPTH - 1)) ? '0
           : rd_q + tmadc_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + tmadc_pkg::QCNT_W'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - tmadc_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/tmadc_divider.sv -----
// Back part: divides both channel remainders by the kept count with a reciprocal multiply.
module tmadc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  tmadc_pkg::scan_word_t       word_i,
  output logic                        pop_o,
  output logic                        done_o,
  output logic [tmadc_pkg::OUT_W-1:0] temp_filtered_o,
  output logic [tmadc_pkg::OUT_W-1:0] sense_filtered_o
);

  localparam logic [tmadc_pkg::RECIP_W-1:0] RecipC =
    tmadc_pkg::RECIP_W'(tmadc_pkg::RECIP);

  logic [tmadc_pkg::PROD_W-1:0] t_prod, s_prod;
  logic [tmadc_pkg::OUT_W-1:0]  t_out_q, t_out_d, s_out_q, s_out_d;
  logic                         done_q, done_d;

  assign pop_o  = !empty_i;
  assign t_prod = tmadc_pkg::PROD_W'(word_i.temp_rest) * tmadc_pkg::PROD_W'(RecipC);
  assign s_prod = tmadc_pkg::PROD_W'(word_i.sense_rest) * tmadc_pkg::PROD_W'(RecipC);

  always_comb begin
    done_d  = pop_o;
    t_out_d = t_out_q;
    s_out_d = s_out_q;
    if (pop_o) begin
      t_out_d = tmadc_pkg::OUT_W'(t_prod >> tmadc_pkg::RECIP_SH);
      s_out_d = tmadc_pkg::OUT_W'(s_prod >> tmadc_pkg::RECIP_SH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      t_out_q <= '0;
      s_out_q <= '0;
    end else begin
      done_q  <= done_d;
      t_out_q <= t_out_d;
      s_out_q <= s_out_d;
    end
  end

  assign done_o           = done_q;
  assign temp_filtered_o  = t_out_q;
  assign sense_filtered_o = s_out_q;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the two-channel trimmed-mean ADC filter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 2 * (tmadc_pkg::SUM_W + 2) + 8;
  localparam int unsigned SCANS_PER_PHASE = 19;
  localparam logic [tmadc_pkg::IN_W-1:0] FULL_SCALE = '1;

  class trimmed_mean_scoreboard;
    typedef struct {
      logic [tmadc_pkg::OUT_W-1:0] temp;
      logic [tmadc_pkg::OUT_W-1:0] sense;
    } scan_means_t;

    int unsigned position = 0;
    int unsigned temp_sum = 0;
    int unsigned temp_low = 0;
    int unsigned temp_high = 0;
    int unsigned sense_sum = 0;
    int unsigned sense_low = 0;
    int unsigned sense_high = 0;
    scan_means_t expected_means[$];
    int unsigned failures = 0;
    int unsigned words_seen = 0;
    int unsigned results_checked = 0;

    function logic [tmadc_pkg::OUT_W-1:0] trimmed_mean(int unsigned sum, int unsigned lo,
                                                       int unsigned hi);
      int unsigned divisor;
      divisor = tmadc_pkg::SAMPLES_PER_CHANNEL - 2;
      if (divisor == 0) return '0;
      return tmadc_pkg::OUT_W'((sum - lo - hi) / divisor);
    endfunction

    function void note_sample(logic [tmadc_pkg::IN_W-1:0] word);
      int unsigned value;
      bit first;
      scan_means_t means;
      value = int'(word) & ((1 << tmadc_pkg::SAMPLE_BITS) - 1);
      first = (position >> 1) == 0;
      words_seen++;
      if (position % 2 == 0) begin
        if (first) begin
          temp_sum = value;
          temp_low = value;
          temp_high = value;
        end else begin
          temp_sum += value;
          if (value < temp_low) temp_low = value;
          if (value > temp_high) temp_high = value;
        end
      end else begin
        if (first) begin
          sense_sum = value;
          sense_low = value;
          sense_high = value;
        end else begin
          sense_sum += value;
          if (value < sense_low) sense_low = value;
          if (value > sense_high) sense_high = value;
        end
      end
      if (position + 1 >= 2 * tmadc_pkg::SAMPLES_PER_CHANNEL) begin
        means.temp = trimmed_mean(temp_sum, temp_low, temp_high);
        means.sense = trimmed_mean(sense_sum, sense_low, sense_high);
        expected_means.push_back(means);
        position = 0;
        temp_sum = 0;
        temp_low = 0;
        temp_high = 0;
        sense_sum = 0;
        sense_low = 0;
        sense_high = 0;
      end else begin
        position++;
      end
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_result(logic [tmadc_pkg::OUT_W-1:0] temp,
                               logic [tmadc_pkg::OUT_W-1:0] sense);
      scan_means_t want;
      if (expected_means.size() == 0) begin
        report($sformatf("unexpected result temp=%0d sense=%0d", temp, sense));
        return;
      end
      want = expected_means.pop_front();
      results_checked++;
      if (temp !== want.temp)
        report($sformatf("temp_filtered expected %0d got %0d", want.temp, temp));
      if (sense !== want.sense)
        report($sformatf("sense_filtered expected %0d got %0d", want.sense, sense));
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [tmadc_pkg::IN_W-1:0] sample_i;
  logic done_o;
  logic [tmadc_pkg::OUT_W-1:0] temp_filtered_o;
  logic [tmadc_pkg::OUT_W-1:0] sense_filtered_o;

  trimmed_mean_scoreboard sb;
  int unsigned idle_pct;
  int unsigned idle_cycles;
  int unsigned scans_sent;

  two_channel_trimmed_mean_adc_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .sample_i         (sample_i),
    .done_o           (done_o),
    .temp_filtered_o  (temp_filtered_o),
    .sense_filtered_o (sense_filtered_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (start && !busy) sb.note_sample(sample_i);
      if (done_o) sb.check_result(temp_filtered_o, sense_filtered_o);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", sb.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [tmadc_pkg::IN_W-1:0] word);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    sample_i <= word;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic random_scan();
    logic [tmadc_pkg::IN_W-1:0] base;
    logic [tmadc_pkg::IN_W-1:0] word;
    int unsigned kind;
    kind = $urandom_range(0, 7);
    base = tmadc_pkg::IN_W'($urandom);
    for (int i = 0; i < 2 * tmadc_pkg::SAMPLES_PER_CHANNEL; i++) begin
      case (kind)
        4: word = base;
        5: word = base + tmadc_pkg::IN_W'($urandom_range(0, 15));
        6: word = $urandom_range(0, 1) ? FULL_SCALE : '0;
        7: begin
          case ($urandom_range(0, 2))
            0: word = '0;
            1: word = FULL_SCALE;
            default: word = base;
          endcase
        end
        default: word = tmadc_pkg::IN_W'($urandom);
      endcase
      send_word(word);
    end
    scans_sent++;
  endtask

  initial begin
    logic [tmadc_pkg::IN_W-1:0] edge_scan [16];
    edge_scan = '{12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'h555, 12'hAAA,
                  12'h800, 12'h000, 12'h001, 12'h7FF, 12'hFFE, 12'h001, 12'h7FF, 12'hFFF};
    sb = new();
    idle_pct = 0;
    idle_cycles = 0;
    scans_sent = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    sample_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 2 * tmadc_pkg::SAMPLES_PER_CHANNEL; i++) begin
      send_word(edge_scan[i % 16]);
    end
    scans_sent++;
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: idle_pct = 33;
        1: idle_pct = 45;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < SCANS_PER_PHASE; n++) begin
        random_scan();
        if ($urandom_range(0, 7) == 0) drain_results();
      end
      drain_results();
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Fed %0d sample words in %0d scans; %0d pairs of trimmed means compared.",
             sb.words_seen, scans_sent, sb.results_checked);
    $display("Scans mixed full-range, constant, narrow-band and extreme-value samples.");
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total", sb.failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- two_channel_trimmed_mean_adc_filter.f -----
design/tmadc_pkg.sv
design/tmadc_front.sv
design/tmadc_queue.sv
design/tmadc_divider.sv
design/two_channel_trimmed_mean_adc_filter.sv
sim/tb.sv
